/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/mtep_pkg.sv */
`default_nettype none
package mtep_pkg;

   localparam int PHW = 4;

   localparam logic [PHW-1:0] PH_TAG       = 4'd0;
   localparam logic [PHW-1:0] PH_LEN       = 4'd1;
   localparam logic [PHW-1:0] PH_DELTA     = 4'd2;
   localparam logic [PHW-1:0] PH_STATUS    = 4'd3;
   localparam logic [PHW-1:0] PH_DATA1     = 4'd4;
   localparam logic [PHW-1:0] PH_DATA2     = 4'd5;
   localparam logic [PHW-1:0] PH_META_TYPE = 4'd6;
   localparam logic [PHW-1:0] PH_META_LEN  = 4'd7;
   localparam logic [PHW-1:0] PH_META_BODY = 4'd8;
   localparam logic [PHW-1:0] PH_SYSEX_LEN = 4'd9;
   localparam logic [PHW-1:0] PH_SKIP      = 4'd10;
   localparam logic [PHW-1:0] PH_TAIL      = 4'd11;
   localparam logic [PHW-1:0] PH_HALT      = 4'd12;

   localparam logic [3:0] K_ON        = 4'd0;
   localparam logic [3:0] K_CLOSED    = 4'd1;
   localparam logic [3:0] K_UNMATCHED = 4'd2;
   localparam logic [3:0] K_TEMPO     = 4'd3;
   localparam logic [3:0] K_TIME      = 4'd4;
   localparam logic [3:0] K_KEY       = 4'd5;
   localparam logic [3:0] K_TEXT      = 4'd6;
   localparam logic [3:0] K_END       = 4'd7;
   localparam logic [3:0] K_ERROR     = 4'd8;
   localparam logic [3:0] K_UNKNOWN   = 4'd9;
   localparam logic [3:0] K_SEQ       = 4'd10;

   localparam logic [31:0] ERR_TAG     = 32'd1;
   localparam logic [31:0] ERR_LENGTH  = 32'd2;
   localparam logic [31:0] ERR_RUNNING = 32'd3;
   localparam logic [31:0] ERR_STATUS  = 32'd4;

   localparam logic [31:0] MTRK_TAG = 32'h4d54726b;

   localparam logic [7:0] META_SEQ   = 8'h00;
   localparam logic [7:0] META_END   = 8'h2f;
   localparam logic [7:0] META_TEMPO = 8'h51;
   localparam logic [7:0] META_SMPTE = 8'h54;
   localparam logic [7:0] META_TIME  = 8'h58;
   localparam logic [7:0] META_KEY   = 8'h59;
   localparam logic [7:0] META_SEQSP = 8'h7f;

   localparam logic [1:0] SEL_PRIM  = 2'd0;
   localparam logic [1:0] SEL_FLUSH = 2'd1;
   localparam logic [1:0] SEL_END   = 2'd2;

   typedef struct packed {
      logic       take;
      logic       decode;
      logic       load;
      logic       flush_next;
      logic [1:0] sel;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic dec_prim;
      logic dec_flush;
      logic dec_end;
      logic flush_any;
      logic end_pend;
      logic fi_last;
   } dp_stat_type;

   // one data byte follows these statuses, two follow the rest
   function automatic logic one_data(input logic [7:0] st);
      return ((st >= 8'h60) && (st <= 8'h79)) || ((st >= 8'hc0) && (st <= 8'hdf));
   endfunction

endpackage
`default_nettype wire

/* rtl/core/midi_track_event_parser.sv */
// MIDI track chunk parser. Feed the chunk one byte per transfer, tag first;
// each byte yields zero or more result transfers, the final one of the byte
// marked by rsp_tlast (at most OPEN_NOTES+1 per byte, excess dropped).
// A byte is accepted, then decoded, in the parse controller; closing all open
// notes at track end or on an all-notes-off walks the note table one entry
// per cycle, and each result is loaded, while the result side keeps up.
// After an error every byte is swallowed until reset.
`default_nettype none
`include "assert_macros.svh"
module midi_track_event_parser #(
   parameter int OPEN_NOTES = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // data_byte
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // channel[3:0], pitch[10:4], velocity[17:11], event_tick[49:18],
   // start_tick[81:50], value[113:82], zero pad
   output logic [119:0] rsp_tdata,
   output logic [3:0]   rsp_tuser,   // event_kind
   output logic         rsp_tlast    // last
);
   import mtep_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   logic [3:0]  event_kind, channel;
   logic [6:0]  pitch, velocity;
   logic [31:0] event_tick, start_tick, value;

   // byte sequencing and result handshake
   mtep_ctrl #(.OPEN_NOTES(OPEN_NOTES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // parse state, note table and output register
   mtep_datapath #(.OPEN_NOTES(OPEN_NOTES)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .event_kind (event_kind),
      .channel    (channel),
      .pitch      (pitch),
      .velocity   (velocity),
      .event_tick (event_tick),
      .start_tick (start_tick),
      .value      (value),
      .last       (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, value, start_tick, event_tick, velocity, pitch, channel};
   assign rsp_tuser = event_kind;

   // one byte in flight at a time
   `ASSERT_NEXT(a_one_byte, clock, reset, req_tvalid && req_tready, !req_tready, "byte overlap")
   // a result is never loaded over one still waiting
   `ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load, !rsp_tvalid || rsp_tready, "result lost")

endmodule
`default_nettype wire

/* rtl/core/mtep_ctrl.sv */
`default_nettype none
module mtep_ctrl #(
   parameter int OPEN_NOTES = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output mtep_pkg::dp_cmd_type cmd,
   input  mtep_pkg::dp_stat_type stat
);
   import mtep_pkg::*;

   localparam int CW = $clog2(OPEN_NOTES + 2);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEC   = 3'd1;
   localparam logic [2:0] S_PRIM  = 3'd2;
   localparam logic [2:0] S_FLUSH = 3'd3;
   localparam logic [2:0] S_END   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          valid_ff, valid_in;
   logic          slot_free, capped, near;

   assign slot_free  = !valid_ff || rsp_tready;
   assign capped     = (cnt_ff == CW'(OPEN_NOTES + 1));
   assign near       = (cnt_ff == CW'(OPEN_NOTES));
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            cmd.decode = 1'b1;
            cnt_in     = '0;
            if (stat.dec_prim)       state_in = S_PRIM;
            else if (stat.dec_flush) state_in = S_FLUSH;
            else if (stat.dec_end)   state_in = S_END;
            else                     state_in = S_IDLE;
         end
         S_PRIM: begin
            if (capped) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               cmd.load = 1'b1;
               cmd.sel  = SEL_PRIM;
               cmd.last = near || (!stat.flush_any && !stat.end_pend);
               cnt_in   = cnt_ff + 1'b1;
               if (stat.flush_any)     state_in = S_FLUSH;
               else if (stat.end_pend) state_in = S_END;
               else                    state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (capped) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               cmd.load       = 1'b1;
               cmd.flush_next = 1'b1;
               cmd.sel        = SEL_FLUSH;
               cmd.last       = near || (stat.fi_last && !stat.end_pend);
               cnt_in         = cnt_ff + 1'b1;
               if (stat.fi_last) state_in = stat.end_pend ? S_END : S_IDLE;
            end
         end
         S_END: begin
            if (capped) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               cmd.load = 1'b1;
               cmd.sel  = SEL_END;
               cmd.last = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      valid_in = cmd.load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/mtep_datapath.sv */
`default_nettype none
module mtep_datapath #(
   parameter int OPEN_NOTES = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [7:0]            data_byte,
   input  mtep_pkg::dp_cmd_type  cmd,
   output mtep_pkg::dp_stat_type stat,
   output logic [3:0]            event_kind,
   output logic [3:0]            channel,
   output logic [6:0]            pitch,
   output logic [6:0]            velocity,
   output logic [31:0]           event_tick,
   output logic [31:0]           start_tick,
   output logic [31:0]           value,
   output logic                  last
);
   import mtep_pkg::*;

   localparam int IW = (OPEN_NOTES > 1) ? $clog2(OPEN_NOTES) : 1;
   localparam int FW = $clog2(OPEN_NOTES + 1);

   // parse state
   logic [7:0]     byte_ff;
   logic [PHW-1:0] phase_ff, phase_in;
   logic [31:0]    bc_ff, bc_in, cl_ff, cl_in, tick_ff, tick_in;
   logic [31:0]    la_ff, la_in, skip_ff, skip_in, fg_ff, fg_in;
   logic [7:0]     rs_ff, rs_in, es_ff, es_in;
   logic [FW-1:0]  fill_ff, fill_in;

   // note table, entries below fill_ff are live
   logic [10:0]    key_ff   [OPEN_NOTES];
   logic [31:0]    start_ff [OPEN_NOTES];

   // results of one decode
   logic           prim_in, end_ff, end_in;
   logic [3:0]     pkind_ff, pkind_in;
   logic [3:0]     pch_ff, pch_in;
   logic [6:0]     ppitch_ff, ppitch_in, pvel_ff, pvel_in;
   logic [31:0]    pstart_ff, pstart_in, pval_ff, pval_in;
   logic [31:0]    etick_ff, etick_in;
   logic [FW-1:0]  fcnt_ff, fcnt_in;
   logic [IW-1:0]  fi_ff;

   // table operations
   logic           wr_en, del_en;
   logic [IW-1:0]  del_idx;

   always_comb begin
      logic [PHW-1:0] ph;
      logic [31:0]    bc, cl, tk, la, sk, fg, len, shown;
      logic [7:0]     rs, es, b;
      logic [FW-1:0]  fill;
      logic           c_go, fl7, evd, eot, mtail, found;
      logic [7:0]     c_st, c_d1, c_d2;
      logic [10:0]    key;
      ph = phase_ff; bc = bc_ff; cl = cl_ff; tk = tick_ff; la = la_ff;
      sk = skip_ff; fg = fg_ff; rs = rs_ff; es = es_ff; fill = fill_ff;
      b = byte_ff;
      c_go = 1'b0; fl7 = 1'b0; evd = 1'b0; eot = 1'b0; mtail = 1'b0; found = 1'b0;
      c_st = '0; c_d1 = '0; c_d2 = '0; len = '0; key = '0;
      prim_in = 1'b0; end_in = 1'b0; pkind_in = K_ON; pch_in = '0; ppitch_in = '0;
      pvel_in = '0; pstart_in = '0; pval_in = '0; fcnt_in = '0;
      wr_en = 1'b0; del_en = 1'b0; del_idx = '0;
      shown = '0;

      if ((ph >= PH_DELTA) && (ph <= PH_TAIL)) bc = bc + 32'd1;

      case (ph)
         PH_TAG: begin
            fg = {fg[23:0], b};
            sk = sk + 32'd1;
            if (sk >= 32'd4) begin
               sk = '0;
               if (fg != MTRK_TAG) begin
                  prim_in = 1'b1; pkind_in = K_ERROR; pval_in = ERR_TAG; ph = PH_HALT;
               end else begin
                  fg = '0; ph = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            fg = {fg[23:0], b};
            sk = sk + 32'd1;
            if (sk >= 32'd4) begin
               sk = '0;
               if (fg[31]) begin
                  prim_in = 1'b1; pkind_in = K_ERROR; pval_in = ERR_LENGTH; ph = PH_HALT;
               end else begin
                  cl = fg; bc = '0; fg = '0;
                  if (cl == '0) begin
                     eot = 1'b1; ph = PH_TAG;
                  end else begin
                     la = '0; ph = PH_DELTA;
                  end
               end
            end
         end
         PH_DELTA: begin
            la = {la[24:0], b[6:0]};
            if (!b[7]) begin
               tk = tk + la; la = '0; ph = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (b <= 8'h5f) begin
               if (rs < 8'h80) begin
                  prim_in = 1'b1; pkind_in = K_ERROR; pval_in = ERR_RUNNING; ph = PH_HALT;
               end else begin
                  es = rs;
                  if (one_data(rs)) begin
                     c_go = 1'b1; c_st = rs; c_d1 = b;
                  end else begin
                     fg = {24'd0, b}; ph = PH_DATA2;
                  end
               end
            end else if (b < 8'hf0) begin
               if (b >= 8'h80) rs = b;
               es = b; ph = PH_DATA1;
            end else if ((b == 8'hf0) || (b == 8'hf7)) begin
               la = '0; ph = PH_SYSEX_LEN;
            end else if (b == 8'hff) begin
               ph = PH_META_TYPE;
            end else begin
               prim_in = 1'b1; pkind_in = K_ERROR; pval_in = ERR_STATUS; ph = PH_HALT;
            end
         end
         PH_DATA1: begin
            if (one_data(es)) begin
               c_go = 1'b1; c_st = es; c_d1 = b;
            end else begin
               fg = {24'd0, b}; ph = PH_DATA2;
            end
         end
         PH_DATA2: begin
            c_go = 1'b1; c_st = es; c_d1 = fg[7:0]; c_d2 = b;
         end
         PH_META_TYPE: begin
            es = b; la = '0; ph = PH_META_LEN;
         end
         PH_META_LEN, PH_SYSEX_LEN: begin
            la = {la[24:0], b[6:0]};
            if (!b[7]) begin
               len = la; la = '0;
               shown = {es, (len > 32'h00ffffff) ? 24'hffffff : len[23:0]};
               if (ph == PH_SYSEX_LEN) begin
                  if (len == '0) evd = 1'b1;
                  else begin sk = len; ph = PH_SKIP; end
               end else if ((es == META_END) && (len == '0)) begin
                  eot = 1'b1; mtail = 1'b1;
               end else if (((es == META_SEQ) && (len == 32'd2)) ||
                            ((es == META_TEMPO) && (len == 32'd3)) ||
                            ((es == META_TIME) && (len == 32'd4)) ||
                            ((es == META_KEY) && (len == 32'd2))) begin
                  fg = '0; sk = len; ph = PH_META_BODY;
               end else begin
                  if ((es == META_SMPTE) && (len == 32'd5)) begin
                     prim_in = 1'b0;
                  end else if (((es >= 8'h01) && (es <= 8'h07)) || (es == META_SEQSP)) begin
                     prim_in = 1'b1; pkind_in = K_TEXT; pval_in = shown;
                  end else begin
                     prim_in = 1'b1; pkind_in = K_UNKNOWN; pval_in = shown;
                  end
                  if (len == '0) evd = 1'b1;
                  else begin sk = len; ph = PH_SKIP; end
               end
            end
         end
         PH_META_BODY: begin
            fg = {fg[23:0], b};
            if (sk <= 32'd1) begin
               sk = '0; prim_in = 1'b1; evd = 1'b1;
               if (es == META_SEQ) begin
                  pkind_in = K_SEQ; pval_in = {16'd0, fg[15:0]};
               end else if (es == META_TEMPO) begin
                  pkind_in = K_TEMPO; pval_in = {8'd0, fg[23:0]};
               end else if (es == META_TIME) begin
                  pkind_in = K_TIME; pval_in = fg;
               end else begin
                  pkind_in = K_KEY; pval_in = {16'd0, fg[15:0]};
               end
            end else begin
               sk = sk - 32'd1;
            end
         end
         PH_SKIP: begin
            if (sk <= 32'd1) begin
               sk = '0; evd = 1'b1;
            end else begin
               sk = sk - 32'd1;
            end
         end
         PH_TAIL: begin
            if (sk <= 32'd1) begin
               sk = '0; ph = PH_TAG;
            end else begin
               sk = sk - 32'd1;
            end
         end
         default: ph = PH_HALT;
      endcase

      // channel event
      if (c_go) begin
         evd = 1'b1;
         key = {c_st[3:0], c_d1[6:0]};
         pch_in = c_st[3:0]; ppitch_in = c_d1[6:0];
         if ((c_st >= 8'h7a) && (c_st <= 8'h7f)) begin
            fl7 = 1'b1;
         end else if ((c_st[7:4] == 4'h9) && (c_d2[6:0] != 7'd0)) begin
            prim_in = 1'b1; pkind_in = K_ON; pvel_in = c_d2[6:0]; pstart_in = tk;
            if (fill < FW'(OPEN_NOTES)) begin
               wr_en = 1'b1; fill = fill + 1'b1;
            end else begin
               pval_in = 32'd1;
            end
         end else if ((c_st[7:4] == 4'h8) || (c_st[7:4] == 4'h9)) begin
            prim_in = 1'b1;
            for (int i = OPEN_NOTES - 1; i >= 0; i--) begin
               if ((FW'(i) < fill_ff) && (key_ff[i] == key)) begin
                  found = 1'b1; del_idx = IW'(i);
               end
            end
            if (found) begin
               pkind_in = K_CLOSED; pstart_in = start_ff[del_idx];
               del_en = 1'b1; fill = fill - 1'b1;
            end else begin
               pkind_in = K_UNMATCHED;
            end
         end
      end

      if (fl7) begin
         fcnt_in = fill; fill = '0;
      end
      if (evd) begin
         if (bc >= cl) begin
            eot = 1'b1; ph = PH_TAG;
         end else begin
            la = '0; ph = PH_DELTA;
         end
      end
      etick_in = tk;
      if (eot) begin
         if (fill != '0) fcnt_in = fill;
         fill = '0; end_in = 1'b1;
         tk = '0; rs = '0; la = '0; fg = '0; sk = '0;
      end
      if (mtail) begin
         if (bc < cl) begin
            sk = cl - bc; ph = PH_TAIL;
         end else begin
            ph = PH_TAG;
         end
      end

      phase_in = ph; bc_in = bc; cl_in = cl; tick_in = tk; la_in = la;
      skip_in = sk; fg_in = fg; rs_in = rs; es_in = es; fill_in = fill;
   end

   assign stat.dec_prim  = prim_in;
   assign stat.dec_flush = (fcnt_in != '0);
   assign stat.dec_end   = end_in;
   assign stat.flush_any = (fcnt_ff != '0);
   assign stat.end_pend  = end_ff;
   assign stat.fi_last   = ((FW'(fi_ff) + FW'(1)) == fcnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         bc_ff    <= '0;
         cl_ff    <= '0;
         tick_ff  <= '0;
         la_ff    <= '0;
         skip_ff  <= '0;
         fg_ff    <= '0;
         rs_ff    <= '0;
         es_ff    <= '0;
         fill_ff  <= '0;
         end_ff   <= 1'b0;
         fcnt_ff  <= '0;
         fi_ff    <= '0;
      end else begin
         if (cmd.decode) begin
            phase_ff <= phase_in;
            bc_ff    <= bc_in;
            cl_ff    <= cl_in;
            tick_ff  <= tick_in;
            la_ff    <= la_in;
            skip_ff  <= skip_in;
            fg_ff    <= fg_in;
            rs_ff    <= rs_in;
            es_ff    <= es_in;
            fill_ff  <= fill_in;
            end_ff   <= end_in;
            fcnt_ff  <= fcnt_in;
            fi_ff    <= '0;
         end else if (cmd.flush_next) begin
            fi_ff <= fi_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) byte_ff <= data_byte;
      if (cmd.decode) begin
         pkind_ff  <= pkind_in;
         pch_ff    <= pch_in;
         ppitch_ff <= ppitch_in;
         pvel_ff   <= pvel_in;
         pstart_ff <= pstart_in;
         pval_ff   <= pval_in;
         etick_ff  <= etick_in;
         // start tick is the tick of this event, before any track-end clear
         if (wr_en) begin
            key_ff[fill_ff[IW-1:0]]   <= {pch_in, ppitch_in};
            start_ff[fill_ff[IW-1:0]] <= etick_in;
         end
         if (del_en) begin
            for (int j = 0; j < OPEN_NOTES - 1; j++) begin
               if (IW'(j) >= del_idx) begin
                  key_ff[j]   <= key_ff[j+1];
                  start_ff[j] <= start_ff[j+1];
               end
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         event_tick <= etick_ff;
         last       <= cmd.last;
         case (cmd.sel)
            SEL_PRIM: begin
               event_kind <= pkind_ff;
               channel    <= pch_ff;
               pitch      <= ppitch_ff;
               velocity   <= pvel_ff;
               start_tick <= pstart_ff;
               value      <= pval_ff;
            end
            SEL_FLUSH: begin
               event_kind <= K_CLOSED;
               channel    <= key_ff[fi_ff][10:7];
               pitch      <= key_ff[fi_ff][6:0];
               velocity   <= '0;
               start_tick <= start_ff[fi_ff];
               value      <= '0;
            end
            default: begin
               event_kind <= K_END;
               channel    <= '0;
               pitch      <= '0;
               velocity   <= '0;
               start_tick <= '0;
               value      <= '0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire
